// File: hw/rtl/nmpn_pkg.sv
// ---------------------------------------------------------------------------
// nmpn_pkg
// shared widths and word types for the normal map pixel normaliser
// ---------------------------------------------------------------------------
package nmpn_pkg;

  // channel width and derived arithmetic widths
  localparam int CH_BITS   = 8;
  localparam int FRAC_BITS = CH_BITS - 1;          // bits of the scaled magnitude
  localparam int AV_BITS   = CH_BITS;              // |2c - M|
  localparam int SQ_BITS   = 2 * AV_BITS;          // square of one component
  localparam int SUM_BITS  = SQ_BITS + 2;          // sum of three squares
  localparam int M_BITS    = CH_BITS + AV_BITS;    // M * |v|
  localparam int P_BITS    = 2 * M_BITS;           // (M * |v|)^2
  localparam int U_BITS    = SUM_BITS + FRAC_BITS; // S * f
  localparam int T_BITS    = SUM_BITS + 2 * FRAC_BITS; // S * f^2
  localparam int CMP_BITS  = T_BITS + 2;           // 4 * S * f^2
  localparam int LANES     = 3;
  localparam int STEPS     = FRAC_BITS;            // one search stage per bit

  localparam logic [CH_BITS-1:0] CH_HALF = CH_BITS'(1 << (CH_BITS - 1));

  // one colour component during the square-root free search
  typedef struct packed {
    logic                 neg;  // component is negative
    logic [P_BITS-1:0]    p;    // (M * |v|)^2
    logic [T_BITS-1:0]    t;    // S * f^2
    logic [U_BITS-1:0]    u;    // S * f
    logic [FRAC_BITS-1:0] f;    // scaled magnitude found so far
  } lane_t;

  // whole pixel word travelling through the search stages
  typedef struct packed {
    lane_t [LANES-1:0]   lane;
    logic [SUM_BITS-1:0] s;     // squared length
    logic [CH_BITS-1:0]  alpha;
    logic                last;
  } search_t;

endpackage

// File: hw/rtl/nmpn_search_step.sv
// ---------------------------------------------------------------------------
// nmpn_search_step
// one registered bit of the magnitude search, all three components at once
// ---------------------------------------------------------------------------
module nmpn_search_step import nmpn_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  search_t in_word,
  output logic    out_valid,
  output search_t out_word
);

  search_t word_next;

  // S*(f+2^b)^2 = S*f^2 + S*f*2^(b+1) + S*2^(2b), shifts and adds only
  always_comb begin
    logic [CMP_BITS-1:0] t_cand;
    word_next = in_word;
    for (int i = 0; i < LANES; i++) begin
      t_cand = CMP_BITS'(in_word.lane[i].t)
             + (CMP_BITS'(in_word.lane[i].u) << (BIT + 1))
             + (CMP_BITS'(in_word.s) << (2 * BIT));
      if ((t_cand << 2) <= CMP_BITS'(in_word.lane[i].p)) begin
        word_next.lane[i].t = t_cand[T_BITS-1:0];
        word_next.lane[i].u = in_word.lane[i].u + (U_BITS'(in_word.s) << BIT);
        word_next.lane[i].f = in_word.lane[i].f | (FRAC_BITS'(1) << BIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

// File: hw/rtl/normal_map_pixel_normalize.sv
// ---------------------------------------------------------------------------
// normal_map_pixel_normalize
// renormalises, unless stalled, one rgba normal map pixel per clock
// ---------------------------------------------------------------------------
// Each colour byte c stands for the odd component v = 2c - 255, so the vector
// is never zero. Every component is scaled to unit length and written back as
// round(127.5 + 127.5 * v / |V|) with |V| the vector length, ties rounding
// up; alpha and tlast pass through untouched. The answer is exact: the scaled
// magnitude is found bit by bit by comparing 4*S*f^2 against (255*|v|)^2,
// with S*f^2 and S*f kept as running sums so no square root or divider is
// needed. Throughput is one word per clock unless the master side stalls; a
// word passes one decode stage, one squaring stage, one sum and product
// stage, seven search stages and one output stage. Every stage has its own
// valid bit and fills a bubble even while the output register is held, so a
// stall on the master side loses and repeats nothing.
// ---------------------------------------------------------------------------
module normal_map_pixel_normalize import nmpn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input pixel stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // red_in, green_in, blue_in, alpha_in
  input  logic        s_axis_tlast,   // last_in
  // output pixel stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
  output logic        m_axis_tlast    // last_out
);

  // stage enables, from the output back to the input
  logic en_a, en_b, en_c, en_o;
  logic [STEPS-1:0] en_step;

  // stage a: magnitude and sign of each component
  logic                             a_valid;
  logic [LANES-1:0][AV_BITS-1:0]    a_av;
  logic [LANES-1:0]                 a_neg;
  logic [CH_BITS-1:0]               a_alpha;
  logic                             a_last;

  // stage b: square and M*|v| of each component
  logic                             b_valid;
  logic [LANES-1:0][SQ_BITS-1:0]    b_sq;
  logic [LANES-1:0][M_BITS-1:0]     b_m;
  logic [LANES-1:0]                 b_neg;
  logic [CH_BITS-1:0]               b_alpha;
  logic                             b_last;

  // stage c: squared length and comparison targets
  logic                             c_valid;
  search_t                          c_word;
  search_t                          c_word_next;

  // search stages
  logic    [STEPS-1:0]              step_valid;
  search_t [STEPS-1:0]              step_word;

  // output register
  logic                             o_valid;
  logic [LANES-1:0][CH_BITS-1:0]    o_ch;
  logic [LANES-1:0][CH_BITS-1:0]    o_ch_next;
  logic [CH_BITS-1:0]               o_alpha;
  logic                             o_last;

  // ------------------------------------------------------------------------
  // flow control: a stage moves when it is empty or the next one moves
  // ------------------------------------------------------------------------
  assign en_o = !o_valid || m_axis_tready;

  for (genvar k = 0; k < STEPS; k++) begin : g_en
    if (k == STEPS - 1) begin : g_tail
      assign en_step[k] = !step_valid[k] || en_o;
    end else begin : g_mid
      assign en_step[k] = !step_valid[k] || en_step[k+1];
    end
  end

  assign en_c = !c_valid || en_step[0];
  assign en_b = !b_valid || en_c;
  assign en_a = !a_valid || en_b;

  assign s_axis_tready = en_a;

  // ------------------------------------------------------------------------
  // stage a: |2c - 255| is c[6:0] (or its complement) with a one appended
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      for (int i = 0; i < LANES; i++) begin
        a_neg[i] <= !s_axis_tdata[i*CH_BITS + CH_BITS - 1];
        a_av[i]  <= {s_axis_tdata[i*CH_BITS +: FRAC_BITS]
                     ^ {FRAC_BITS{!s_axis_tdata[i*CH_BITS + CH_BITS - 1]}}, 1'b1};
      end
      a_alpha <= s_axis_tdata[LANES*CH_BITS +: CH_BITS];
      a_last  <= s_axis_tlast;
    end
  end

  // ------------------------------------------------------------------------
  // stage b: v^2 and 255*|v|
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      for (int i = 0; i < LANES; i++) begin
        b_sq[i] <= SQ_BITS'(a_av[i]) * SQ_BITS'(a_av[i]);
        b_m[i]  <= (M_BITS'(a_av[i]) << CH_BITS) - M_BITS'(a_av[i]);
      end
      b_neg   <= a_neg;
      b_alpha <= a_alpha;
      b_last  <= a_last;
    end
  end

  // ------------------------------------------------------------------------
  // stage c: S = sum of squares, p = (255*|v|)^2, search starts at zero
  // ------------------------------------------------------------------------
  always_comb begin
    c_word_next.s = SUM_BITS'(b_sq[0]) + SUM_BITS'(b_sq[1]) + SUM_BITS'(b_sq[2]);
    for (int i = 0; i < LANES; i++) begin
      c_word_next.lane[i].neg = b_neg[i];
      c_word_next.lane[i].p   = P_BITS'(b_m[i]) * P_BITS'(b_m[i]);
      c_word_next.lane[i].t   = '0;
      c_word_next.lane[i].u   = '0;
      c_word_next.lane[i].f   = '0;
    end
    c_word_next.alpha = b_alpha;
    c_word_next.last  = b_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en_c) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_word <= c_word_next;
    end
  end

  // ------------------------------------------------------------------------
  // search: one bit of the scaled magnitude per stage, top bit first
  // ------------------------------------------------------------------------
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      nmpn_search_step #(
        .BIT (STEPS - 1 - k)
      ) u_step (
        .clk       (clk),
        .rst       (rst),
        .en        (en_step[k]),
        .in_valid  (c_valid),
        .in_word   (c_word),
        .out_valid (step_valid[k]),
        .out_word  (step_word[k])
      );
    end else begin : g_next
      nmpn_search_step #(
        .BIT (STEPS - 1 - k)
      ) u_step (
        .clk       (clk),
        .rst       (rst),
        .en        (en_step[k]),
        .in_valid  (step_valid[k-1]),
        .in_word   (step_word[k-1]),
        .out_valid (step_valid[k]),
        .out_word  (step_word[k])
      );
    end
  end

  // ------------------------------------------------------------------------
  // output: 128 + f for positive components; 127 - f for negative ones,
  // 128 - f when the product lands exactly on the boundary
  // ------------------------------------------------------------------------
  always_comb begin
    logic exact;
    for (int i = 0; i < LANES; i++) begin
      exact = (CMP_BITS'(step_word[STEPS-1].lane[i].t) << 2)
              == CMP_BITS'(step_word[STEPS-1].lane[i].p);
      if (step_word[STEPS-1].lane[i].neg) begin
        o_ch_next[i] = CH_HALF - CH_BITS'(step_word[STEPS-1].lane[i].f)
                       - CH_BITS'(!exact);
      end else begin
        o_ch_next[i] = CH_HALF + CH_BITS'(step_word[STEPS-1].lane[i].f);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en_o) begin
      o_valid <= step_valid[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      o_ch    <= o_ch_next;
      o_alpha <= step_word[STEPS-1].alpha;
      o_last  <= step_word[STEPS-1].last;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {o_alpha, o_ch[2], o_ch[1], o_ch[0]};
  assign m_axis_tlast  = o_last;

endmodule

// File: sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the normal map pixel normaliser
// ---------------------------------------------------------------------------
// Pixels go in on the slave stream and come back renormalised on the master
// stream. An in-bench predictor works most results out exactly, by searching
// the scaled magnitude bit by bit and comparing squares. A short table of
// directed pixels comes first: axis vectors, the all-zero and all-one
// corners, the centre codes and alpha/last extremes. A random stream follows,
// with idle bursts on both sides, one long output hold and one full drain.
// ---------------------------------------------------------------------------
module testbench import nmpn_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FULL_SCALE     = (1 << CH_BITS) - 1;
  localparam int HALF_CODE      = 1 << (CH_BITS - 1);
  localparam int RANDOM_ITEMS   = 1280;
  localparam int HOLD_AT        = 400;   // pixel count that triggers the long hold
  localparam int HOLD_CYCLES    = 150;   // long output hold, in cycles
  localparam int DRAIN_AT       = 800;   // random pixel index where the sender drains
  localparam int CALM_ITEMS     = 200;   // closing stretch with no idling
  localparam int END_PAUSE      = 32;    // pause after the drain, to catch stray words
  localparam int WATCHDOG_LIMIT = 1000;

  // one pixel word, red in the lowest bits as on the bus
  typedef struct packed {
    logic                last;
    logic [CH_BITS-1:0]  alpha;
    logic [CH_BITS-1:0]  blue;
    logic [CH_BITS-1:0]  green;
    logic [CH_BITS-1:0]  red;
  } pixel_t;

  // one row of the directed table
  typedef struct packed {
    pixel_t px;
    logic   typed;   // expected pixel written in the table
    pixel_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // red_in, green_in, blue_in, alpha_in
  logic        s_axis_tlast = 1'b0; // last_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // red_out, green_out, blue_out, alpha_out
  logic        m_axis_tlast;        // last_out

  pixel_t      pending_pixels[$];   // renormalised pixels still to come out
  row_t        directed_rows[$];
  int unsigned in_count = 0;
  int unsigned out_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  bit          long_hold_done = 1'b0;
  bit          calm = 1'b0;       // no idling on either side from here on

  normal_map_pixel_normalize i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // one component scaled to unit length: half + floor(M*v / (2*sqrt(S))),
  // found by the largest f with 4*S*f^2 <= (M*|v|)^2
  function automatic logic [CH_BITS-1:0] unit_channel(logic [CH_BITS-1:0] code,
                                                      longint unsigned sumsq);
    int              v;
    int              res;
    int              bi;
    longint unsigned mag;
    longint unsigned target;
    longint unsigned trial;
    longint unsigned found;
    v      = 2 * int'(code) - FULL_SCALE;
    mag    = (v < 0) ? longint'(-v) : longint'(v);
    target = (FULL_SCALE * mag) * (FULL_SCALE * mag);
    found  = 0;
    for (bi = CH_BITS - 2; bi >= 0; bi--) begin
      trial = found | (64'd1 << bi);
      if (sumsq * (4 * trial * trial) <= target) found = trial;
    end
    if (v > 0) begin
      res = HALF_CODE + int'(found);
    end else begin
      // below the centre the floor goes one further down unless the split is exact
      res = HALF_CODE - int'(found);
      if (sumsq * (4 * found * found) != target) res = res - 1;
    end
    if (res < 0) res = 0;
    if (res > FULL_SCALE) res = FULL_SCALE;
    return res[CH_BITS-1:0];
  endfunction

  function automatic pixel_t renorm_pixel(pixel_t px);
    int              vr;
    int              vg;
    int              vb;
    longint unsigned sumsq;
    pixel_t          res;
    vr    = 2 * int'(px.red) - FULL_SCALE;
    vg    = 2 * int'(px.green) - FULL_SCALE;
    vb    = 2 * int'(px.blue) - FULL_SCALE;
    sumsq = longint'(vr * vr) + longint'(vg * vg) + longint'(vb * vb);
    res.red   = unit_channel(px.red, sumsq);
    res.green = unit_channel(px.green, sumsq);
    res.blue  = unit_channel(px.blue, sumsq);
    res.alpha = px.alpha;
    res.last  = px.last;
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  task automatic add_row(int r, int g, int b, int a, bit l, bit typed,
                         int wr, int wg, int wb);
    row_t row;
    row.px    = '{last: l, alpha: a[7:0], blue: b[7:0], green: g[7:0], red: r[7:0]};
    row.typed = typed;
    row.want  = '{last: l, alpha: a[7:0], blue: wb[7:0], green: wg[7:0], red: wr[7:0]};
    directed_rows.push_back(row);
  endtask

  // offer one pixel word and hold it until the block takes it
  task automatic send_pixel(pixel_t px, pixel_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {px.alpha, px.blue, px.green, px.red};
    s_axis_tlast  <= px.last;
    do @(posedge clk); while (!s_axis_tready);
    pending_pixels.push_back(want);
    in_count++;
  endtask

  // idle burst on the input side, with junk on the data lines
  task automatic idle_gap(int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= $urandom;
    s_axis_tlast  <= 1'($urandom_range(0, 1));
    repeat (cycles) @(posedge clk);
  endtask

  // one channel byte of a given flavour
  function automatic logic [CH_BITS-1:0] pick_channel(int unsigned flavour);
    case (flavour)
      1: begin
        // close to either end of the code range
        if ($urandom_range(0, 1)) return CH_BITS'($urandom_range(0, 2));
        return CH_BITS'($urandom_range(FULL_SCALE - 2, FULL_SCALE));
      end
      2: begin
        // around the centre, where components are tiny and odd
        return CH_BITS'($urandom_range(HALF_CODE - 4, HALF_CODE + 3));
      end
      default: begin
        return CH_BITS'($urandom_range(0, FULL_SCALE));
      end
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------------

  task automatic check_field(string field, logic [CH_BITS-1:0] want,
                             logic [CH_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    pixel_t seen;
    pixel_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.red   = m_axis_tdata[7:0];
      seen.green = m_axis_tdata[15:8];
      seen.blue  = m_axis_tdata[23:16];
      seen.alpha = m_axis_tdata[31:24];
      seen.last  = m_axis_tlast;
      out_count++;
      if (pending_pixels.size() == 0) begin
        $display("%0t ns: word out with none expected, expected nothing, got %h/%b",
                 $time, m_axis_tdata, m_axis_tlast);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("red", want.red, seen.red);
        check_field("green", want.green, seen.green);
        check_field("blue", want.blue, seen.blue);
        check_field("alpha", want.alpha, seen.alpha);
        check_field("last", CH_BITS'(want.last), CH_BITS'(seen.last));
      end
    end
  end

  // ------------------------------------------------------------------------
  // watchdog: cycles in which no word moves on either side
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d words still expected",
               quiet_cycles, pending_pixels.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // output side: random stall phases, one long hold, calm at the end
  // ------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_pct;
    int unsigned phase_cycles;
    stall_pct    = 0;
    phase_cycles = 0;
    while (rst) @(posedge clk);
    forever begin
      if (phase_cycles == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 10;
          2: stall_pct = 30;
          default: stall_pct = 60;
        endcase
        phase_cycles = 100;
      end
      phase_cycles--;
      if (!long_hold_done && in_count >= HOLD_AT) begin
        // long hold: the pipe fills and the input side has to stall
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(1, 100) <= stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ------------------------------------------------------------------------
  // input side: directed table, then the random stream
  // ------------------------------------------------------------------------
  initial begin : pixel_source
    pixel_t      px;
    pixel_t      want;
    int unsigned gap_pct;
    int unsigned flavour;
    bit          pressure;

    // centre codes: every component +-1, magnitude 1/sqrt(3) of full scale
    add_row(128, 128, 128,   0, 1'b0, 1'b1, 201, 201, 201);
    add_row(127, 127, 127, 255, 1'b1, 1'b1,  54,  54,  54);
    // all-ones and all-zero corners scale the same way
    add_row(255, 255, 255,   0, 1'b1, 1'b1, 201, 201, 201);
    add_row(  0,   0,   0, 255, 1'b0, 1'b1,  54,  54,  54);
    // axis vectors stay where they are
    add_row(255, 128, 128, 170, 1'b0, 1'b1, 255, 128, 128);
    add_row(  0, 128, 128,  85, 1'b1, 1'b1,   0, 128, 128);
    add_row(128, 255, 128,   1, 1'b0, 1'b1, 128, 255, 128);
    add_row(128,   0, 128, 254, 1'b1, 1'b1, 128,   0, 128);
    add_row(128, 128, 255,  15, 1'b0, 1'b1, 128, 128, 255);
    add_row(128, 128,   0, 240, 1'b1, 1'b1, 128, 128,   0);
    // tiny negative components round just below the centre
    add_row(127, 127, 255, 127, 1'b0, 1'b1, 127, 127, 255);
    add_row(127, 128,   0, 128, 1'b1, 1'b1, 127, 128,   0);
    // general directions, left to the predictor
    add_row(255,   0, 255,  85, 1'b0, 1'b0, 0, 0, 0);
    add_row(  0, 255,   0, 170, 1'b1, 1'b0, 0, 0, 0);
    add_row(255, 255,   0,   0, 1'b0, 1'b0, 0, 0, 0);
    add_row(  1, 254, 128, 255, 1'b1, 1'b0, 0, 0, 0);
    add_row(200, 100, 230,  66, 1'b0, 1'b0, 0, 0, 0);
    add_row(129, 126, 200, 153, 1'b1, 1'b0, 0, 0, 0);
    add_row( 64, 192, 255,   7, 1'b0, 1'b0, 0, 0, 0);

    // hold reset, then release it before the directed rows
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      want = directed_rows[i].typed ? directed_rows[i].want
                                    : renorm_pixel(directed_rows[i].px);
      send_pixel(directed_rows[i].px, want);
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 8));
    end

    gap_pct = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == DRAIN_AT) begin
        // pause until the pipe is empty, then start again from cold
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
      end
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (n % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: gap_pct = 0;
          1: gap_pct = 10;
          2: gap_pct = 25;
          default: gap_pct = 50;
        endcase
      end

      flavour = $urandom_range(0, 4);
      if (flavour == 4) begin
        // each channel of its own flavour
        px.red   = pick_channel($urandom_range(0, 2));
        px.green = pick_channel($urandom_range(0, 2));
        px.blue  = pick_channel($urandom_range(0, 2));
      end else begin
        px.red   = pick_channel(flavour);
        px.green = pick_channel(flavour);
        px.blue  = pick_channel(flavour);
      end
      px.alpha = CH_BITS'($urandom_range(0, FULL_SCALE));
      px.last  = ($urandom_range(0, 15) == 0);
      send_pixel(px, renorm_pixel(px));

      // keep offering words around the long hold so the block backs up
      pressure = (in_count + 20 >= HOLD_AT) && (in_count < HOLD_AT + 200);
      if (!calm && !pressure && $urandom_range(1, 100) <= gap_pct) begin
        idle_gap($urandom_range(1, 8));
      end
    end
    s_axis_tvalid <= 1'b0;

    // let everything drain, then wait out END_PAUSE for stray words
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (END_PAUSE) @(posedge clk);

    $display("%0d pixels in, %0d out: axis, corner and centre vectors, then random", in_count,
             out_count);
    $display("directions with input gaps, output stalls, one long hold and one drain");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
